/* hw/rtl/depq_pkg.sv */
// Package for the double-ended priority queue: widths, codes, request and
// response structures, and the control group that drives the cell row.
// No dependencies.
`timescale 1ns / 1ps

package depq_pkg;

    // Field widths and default depth.
    localparam int PRIO_W       = 16;
    localparam int TAG_W        = 8;
    localparam int CMD_W        = 3;
    localparam int STATUS_W     = 2;
    localparam int FILL_W       = 5;
    localparam int CAPACITY_DEF = 16;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DEL_MIN  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DEL_MAX  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PEEK_MIN = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PEEK_MAX = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // Cell operations broadcast along the row.
    localparam int CELL_OP_W = 2;
    localparam logic [CELL_OP_W-1:0] CELL_HOLD   = 2'd0;
    localparam logic [CELL_OP_W-1:0] CELL_INSERT = 2'd1;
    localparam logic [CELL_OP_W-1:0] CELL_SHIFT  = 2'd2;
    localparam logic [CELL_OP_W-1:0] CELL_TRIM   = 2'd3;

    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]         tag;
    } depq_entry_t;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic signed [PRIO_W-1:0] key_priority;
        logic [TAG_W-1:0]         entry_tag;
    } depq_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [PRIO_W-1:0] out_priority;
        logic [TAG_W-1:0]         out_tag;
        logic [FILL_W-1:0]        fill_level;
    } depq_rsp_t;

    typedef struct packed {
        logic [CELL_OP_W-1:0] op;
        depq_entry_t          new_entry;
    } depq_cell_ctrl_t;

endpackage

/* hw/rtl/depq_cell.sv */
// One cell of the sorted row: holds a single entry and its valid bit.
// Depends on depq_pkg.
`timescale 1ns / 1ps

module depq_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  depq_pkg::depq_cell_ctrl_t ctrl,
    input  depq_pkg::depq_entry_t     left_entry,
    input  logic                     left_valid,
    input  logic                     left_after,
    input  depq_pkg::depq_entry_t     right_entry,
    input  logic                     right_valid,
    output depq_pkg::depq_entry_t     entry,
    output logic                     valid,
    output logic                     after
);
    import depq_pkg::*;

    depq_entry_t entry_reg;
    depq_entry_t entry_next;
    logic        valid_reg;
    logic        valid_next;

    // The new entry goes behind this cell when the held priority is strictly higher.
    assign after = valid_reg && (entry_reg.prio > ctrl.new_entry.prio);

    // Next contents depend on the broadcast operation and the neighbours.
    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                valid_next = left_valid;
                if (!after)
                begin
                    entry_next = left_after ? ctrl.new_entry : left_entry;
                end
            end
            CELL_SHIFT:
            begin
                entry_next = right_entry;
                valid_next = right_valid;
            end
            CELL_TRIM:
            begin
                valid_next = valid_reg && right_valid;
            end
            default:
            begin
                entry_next = entry_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    // Valid bit is control state and is cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Entry payload needs no reset.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;

endmodule

/* hw/rtl/double_ended_priority_queue.sv */
// Top level of the double-ended priority queue: command decode, the row of
// sorted cells and the response register. Depends on depq_pkg and depq_cell.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+------------------------------------
//   request | req_valid | req_stall | req_data  (command, priority, tag)
//   result  | rsp_valid | rsp_stall | rsp_data  (status, priority, tag, fill)
//
// For every request the whole row of cells updates at the edge
// that accepts it, and the response is registered at the same edge.
// A new request is taken while the previous response waits, unless that
// response is stalled; then req_stall is raised until it is taken.
// Reset clears the valid bit of every cell and the fill count at once.
`timescale 1ns / 1ps

module double_ended_priority_queue #(
    parameter int CAPACITY = depq_pkg::CAPACITY_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  depq_pkg::depq_req_t req_data,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output depq_pkg::depq_rsp_t rsp_data
);
    import depq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    depq_rsp_t        rsp_reg;
    depq_rsp_t        rsp_next;
    logic             accept;
    logic             full;
    logic             empty;
    depq_cell_ctrl_t  ctrl;
    depq_entry_t      min_entry;

    depq_entry_t cell_entry [CAPACITY];
    logic [CAPACITY-1:0] cell_valid;
    logic [CAPACITY-1:0] cell_after;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);

    // Row of cells, highest priority in cell 0.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        depq_entry_t left_e;
        logic        left_v;
        logic        left_a;
        depq_entry_t right_e;
        logic        right_v;

        if (i == 0)
        begin : g_first
            assign left_e = ctrl.new_entry;
            assign left_v = 1'b1;
            assign left_a = 1'b1;
        end
        else
        begin : g_inner_left
            assign left_e = cell_entry[i-1];
            assign left_v = cell_valid[i-1];
            assign left_a = cell_after[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_e = cell_entry[i];
            assign right_v = 1'b0;
        end
        else
        begin : g_inner_right
            assign right_e = cell_entry[i+1];
            assign right_v = cell_valid[i+1];
        end

        depq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .left_entry  (left_e),
            .left_valid  (left_v),
            .left_after  (left_a),
            .right_entry (right_e),
            .right_valid (right_v),
            .entry       (cell_entry[i]),
            .valid       (cell_valid[i]),
            .after       (cell_after[i])
        );
    end

    // The minimum sits in the last valid cell; each cell gates its own entry.
    always_comb
    begin
        min_entry = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (cell_valid[i] && ((i == CAPACITY - 1) || !cell_valid[(i + 1) % CAPACITY]))
            begin
                min_entry = min_entry | cell_entry[i];
            end
        end
    end

    // Command decode: cell operation, new count and the response.
    always_comb
    begin
        ctrl.op                  = CELL_HOLD;
        ctrl.new_entry.prio      = req_data.key_priority;
        ctrl.new_entry.tag       = req_data.entry_tag;
        count_next               = count_reg;
        rsp_next.status          = STATUS_OK;
        rsp_next.out_priority    = '0;
        rsp_next.out_tag         = '0;
        case (req_data.command)
            CMD_INSERT:
            begin
                if (full)
                begin
                    rsp_next.status = STATUS_FULL;
                end
                else
                begin
                    ctrl.op    = CELL_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_DEL_MIN, CMD_DEL_MAX, CMD_PEEK_MIN, CMD_PEEK_MAX:
            begin
                if (empty)
                begin
                    rsp_next.status = STATUS_EMPTY;
                end
                else
                begin
                    if (req_data.command inside {CMD_DEL_MIN, CMD_PEEK_MIN})
                    begin
                        rsp_next.out_priority = min_entry.prio;
                        rsp_next.out_tag      = min_entry.tag;
                    end
                    else
                    begin
                        rsp_next.out_priority = cell_entry[0].prio;
                        rsp_next.out_tag      = cell_entry[0].tag;
                    end
                    if (req_data.command == CMD_DEL_MIN)
                    begin
                        ctrl.op    = CELL_TRIM;
                        count_next = count_reg - 1'b1;
                    end
                    else if (req_data.command == CMD_DEL_MAX)
                    begin
                        ctrl.op    = CELL_SHIFT;
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                rsp_next.status = STATUS_OK;
            end
        endcase
        rsp_next.fill_level = FILL_W'(count_next);
        if (!accept)
        begin
            ctrl.op    = CELL_HOLD;
            count_next = count_reg;
        end
    end

    // Response valid flag: set by an accepted request, cleared when taken.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Response payload, loaded only by an accepted request.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

/* bench/double_ended_priority_queue_tb.sv */
// Self-checking testbench for double_ended_priority_queue: a directed table, then random
// phases of requests, each response checked against a sorted-row predictor.
// Depends on depq_pkg and the RTL of the queue.
`timescale 1ns / 1ps

module double_ended_priority_queue_tb;

    import depq_pkg::*;

    // Command codes that the block treats as no operation.
    localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

    localparam logic [PRIO_W-1:0] PRIO_MAX = 16'h7FFF;
    localparam logic [PRIO_W-1:0] PRIO_MIN = 16'h8000;

    localparam int PHASES         = 22;
    localparam int PHASE_REQUESTS = 50;
    localparam int LONG_HOLD      = 60;

    typedef struct {
        depq_req_t req;
        bit        typed;
        depq_rsp_t rsp;
    } stim_row_t;

    logic      clk         = 1'b0;
    logic      rst_n       = 1'b0;
    logic      req_valid   = 1'b0;
    logic      req_stall;
    depq_req_t req_data    = '0;
    logic      rsp_valid;
    logic      rsp_stall   = 1'b0;
    depq_rsp_t rsp_data;

    // Predicted contents of the queue, highest priority in cell 0.
    logic signed [PRIO_W-1:0] held_prio [CAPACITY_DEF];
    logic [TAG_W-1:0]         held_tag  [CAPACITY_DEF];
    int                       held_count = 0;

    depq_rsp_t   expected_rsps [$];
    stim_row_t   directed_rows [$];
    int unsigned fault_count       = 0;
    int          req_gap_max       = 3;
    int          rsp_stall_max     = 3;
    bit          long_hold_pending = 1'b0;

    double_ended_priority_queue i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Applies one request to the predicted queue and returns its response.
    function automatic depq_rsp_t queue_apply(input depq_req_t r);
        depq_rsp_t                rsp;
        logic signed [PRIO_W-1:0] key;
        int                       pos;
        int                       idx;
        rsp = '0;
        key = r.key_priority;
        case (r.command)
            CMD_INSERT:
            begin
                if (held_count >= CAPACITY_DEF)
                    rsp.status = STATUS_FULL;
                else
                begin
                    // A new entry goes ahead of all entries of equal priority.
                    pos = 0;
                    while (pos < held_count && held_prio[pos] > key)
                        pos++;
                    for (int i = held_count; i > pos; i--)
                    begin
                        held_prio[i] = held_prio[i-1];
                        held_tag[i]  = held_tag[i-1];
                    end
                    held_prio[pos] = key;
                    held_tag[pos]  = r.entry_tag;
                    held_count++;
                end
            end
            CMD_DEL_MIN, CMD_DEL_MAX, CMD_PEEK_MIN, CMD_PEEK_MAX:
            begin
                if (held_count == 0)
                    rsp.status = STATUS_EMPTY;
                else
                begin
                    idx = (r.command == CMD_DEL_MIN || r.command == CMD_PEEK_MIN) ?
                          held_count - 1 : 0;
                    rsp.out_priority = held_prio[idx];
                    rsp.out_tag      = held_tag[idx];
                    if (r.command == CMD_DEL_MIN)
                        held_count--;
                    else if (r.command == CMD_DEL_MAX)
                    begin
                        for (int i = 0; i + 1 < held_count; i++)
                        begin
                            held_prio[i] = held_prio[i+1];
                            held_tag[i]  = held_tag[i+1];
                        end
                        held_count--;
                    end
                end
            end
            default:
                rsp.status = STATUS_OK;
        endcase
        rsp.fill_level = FILL_W'(held_count);
        return rsp;
    endfunction

    function automatic void add_row(input logic [CMD_W-1:0] cmd, input logic [PRIO_W-1:0] prio,
                                    input logic [TAG_W-1:0] tag, input bit typed,
                                    input logic [STATUS_W-1:0] st,
                                    input logic [PRIO_W-1:0] out_prio,
                                    input logic [TAG_W-1:0] out_tag, input int fill);
        stim_row_t row;
        row.req.command      = cmd;
        row.req.key_priority = prio;
        row.req.entry_tag    = tag;
        row.typed            = typed;
        row.rsp.status       = st;
        row.rsp.out_priority = out_prio;
        row.rsp.out_tag      = out_tag;
        row.rsp.fill_level   = FILL_W'(fill);
        directed_rows.push_back(row);
    endfunction

    // Priorities favour the extremes and a few close values so that ties are common.
    function automatic logic [PRIO_W-1:0] random_priority();
        case ($urandom_range(0, 9))
            0:       return PRIO_MAX;
            1:       return PRIO_MIN;
            2, 3, 4: return PRIO_W'(($urandom_range(0, 4) - 2) * 256);
            default: return PRIO_W'($urandom);
        endcase
    endfunction

    // Phase kinds: 0 mostly inserts, 1 mostly deletes and peeks, 2 balanced, 3 a mix with 35 percent inserts.
    function automatic depq_req_t random_request(input int kind);
        depq_req_t r;
        int        insert_pct;
        int        draw;
        case (kind)
            0:       insert_pct = 80;
            1:       insert_pct = 20;
            2:       insert_pct = 50;
            default: insert_pct = 35;
        endcase
        draw = $urandom_range(0, 99);
        if (draw < 3)
            r.command = CMD_W'($urandom_range(CMD_RSVD5, CMD_RSVD7));
        else if (draw < 3 + insert_pct)
            r.command = CMD_INSERT;
        else
            r.command = CMD_W'($urandom_range(CMD_DEL_MIN, CMD_PEEK_MAX));
        r.key_priority = random_priority();
        r.entry_tag    = TAG_W'($urandom);
        return r;
    endfunction

    function automatic int random_gap_limit();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 4;
            default: return 18;
        endcase
    endfunction

    // Offers one request after a random gap and records its response once accepted.
    // Valid stays high afterwards so that back-to-back requests need no second assignment.
    task automatic send_request(input depq_req_t r, input bit typed, input depq_rsp_t typed_rsp);
        int        gap;
        depq_rsp_t predicted;
        gap = $urandom_range(0, req_gap_max);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do @(posedge clk); while (req_stall);
        predicted = queue_apply(r);
        expected_rsps.push_back(typed ? typed_rsp : predicted);
    endtask

    // Request side: reset, the directed table, then the random phases.
    initial
    begin : request_feed
        int kind;
        // Columns: command, priority, tag, typed answer, status, priority, tag, fill.
        add_row(CMD_PEEK_MIN, 16'h0000, 8'h00, 1, STATUS_EMPTY, 16'h0000, 8'h00, 0);
        add_row(CMD_DEL_MAX,  16'h1234, 8'hA5, 1, STATUS_EMPTY, 16'h0000, 8'h00, 0);
        add_row(CMD_DEL_MIN,  PRIO_MIN, 8'hFF, 1, STATUS_EMPTY, 16'h0000, 8'h00, 0);
        add_row(CMD_PEEK_MAX, PRIO_MAX, 8'h5A, 1, STATUS_EMPTY, 16'h0000, 8'h00, 0);
        add_row(CMD_INSERT,   PRIO_MAX, 8'hFF, 1, STATUS_OK,    16'h0000, 8'h00, 1);
        add_row(CMD_INSERT,   PRIO_MIN, 8'h00, 1, STATUS_OK,    16'h0000, 8'h00, 2);
        add_row(CMD_PEEK_MAX, 16'h0000, 8'h00, 1, STATUS_OK,    PRIO_MAX, 8'hFF, 2);
        add_row(CMD_PEEK_MIN, 16'hFFFF, 8'hFF, 1, STATUS_OK,    PRIO_MIN, 8'h00, 2);
        // Three equal priorities: the newest must sit nearest the maximum end.
        add_row(CMD_INSERT,   16'h0000, 8'h11, 0, STATUS_OK, 16'h0000, 8'h00, 0);
        add_row(CMD_INSERT,   16'h0000, 8'h22, 0, STATUS_OK, 16'h0000, 8'h00, 0);
        add_row(CMD_INSERT,   16'h0000, 8'h33, 0, STATUS_OK, 16'h0000, 8'h00, 0);
        add_row(CMD_PEEK_MAX, 16'h0000, 8'h00, 0, STATUS_OK, 16'h0000, 8'h00, 0);
        add_row(CMD_DEL_MAX,  16'h0000, 8'h00, 0, STATUS_OK, 16'h0000, 8'h00, 0);
        add_row(CMD_DEL_MAX,  16'h0000, 8'h00, 0, STATUS_OK, 16'h0000, 8'h00, 0);
        add_row(CMD_RSVD5,    PRIO_MAX, 8'hFF, 0, STATUS_OK, 16'h0000, 8'h00, 0);
        add_row(CMD_RSVD6,    PRIO_MIN, 8'h80, 0, STATUS_OK, 16'h0000, 8'h00, 0);
        add_row(CMD_RSVD7,    16'hFFFF, 8'h7F, 0, STATUS_OK, 16'h0000, 8'h00, 0);
        add_row(CMD_PEEK_MIN, 16'h0000, 8'h00, 0, STATUS_OK, 16'h0000, 8'h00, 0);
        add_row(CMD_DEL_MIN,  16'h0000, 8'h00, 0, STATUS_OK, 16'h0000, 8'h00, 0);
        add_row(CMD_DEL_MIN,  16'h0000, 8'h00, 0, STATUS_OK, 16'h0000, 8'h00, 0);
        // Deleting the last entry leaves the queue empty.
        add_row(CMD_DEL_MIN,  16'h0000, 8'h00, 0, STATUS_OK, 16'h0000, 8'h00, 0);
        add_row(CMD_DEL_MAX,  16'h0000, 8'h00, 1, STATUS_EMPTY, 16'h0000, 8'h00, 0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            kind          = $urandom_range(0, 3);
            req_gap_max   = random_gap_limit();
            rsp_stall_max = random_gap_limit();
            // Insert flood against a long receiver hold-off, so the input stalls.
            if (phase == 4 || phase == 15)
            begin
                kind              = 0;
                req_gap_max       = 0;
                long_hold_pending = 1'b1;
            end
            // Now and then the request side waits for every response to arrive.
            if (phase == 8 || $urandom_range(0, 3) == 0)
            begin
                req_valid <= 1'b0;
                do @(posedge clk); while (expected_rsps.size() != 0);
            end
            repeat (PHASE_REQUESTS)
                send_request(random_request(kind), 1'b0, '0);
        end
        req_valid <= 1'b0;

        // Let the last responses drain, then wait on for anything unexpected.
        for (int i = 0; i < 4000 && expected_rsps.size() != 0; i++)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (expected_rsps.size() != 0)
        begin
            $error("%0d responses never arrived", expected_rsps.size());
            fault_count++;
        end
        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Response side: a random stall before each response, and the long hold-off on demand.
    initial
    begin : result_drain
        int hold;
        forever
        begin
            if (long_hold_pending)
            begin
                hold              = LONG_HOLD;
                long_hold_pending = 1'b0;
            end
            else
                hold = $urandom_range(0, rsp_stall_max);
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            do @(posedge clk); while (!(rsp_valid === 1'b1 && !rsp_stall));
        end
    end

    // Every accepted response is compared with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        depq_rsp_t want;
        if (rst_n && rsp_valid === 1'b1 && !rsp_stall)
        begin
            if (expected_rsps.size() == 0)
            begin
                $error("unexpected response %p", rsp_data);
                fault_count++;
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (rsp_data.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                    fault_count++;
                end
                if (rsp_data.out_priority !== want.out_priority)
                begin
                    $error("out_priority: expected %0d, got %0d",
                           want.out_priority, rsp_data.out_priority);
                    fault_count++;
                end
                if (rsp_data.out_tag !== want.out_tag)
                begin
                    $error("out_tag: expected %0d, got %0d", want.out_tag, rsp_data.out_tag);
                    fault_count++;
                end
                if (rsp_data.fill_level !== want.fill_level)
                begin
                    $error("fill_level: expected %0d, got %0d",
                           want.fill_level, rsp_data.fill_level);
                    fault_count++;
                end
            end
        end
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
